// ----- rtl/core/button_gesture_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// button gesture classifier assertion macros
// shared property shapes, clocked on aclk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define BGC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bgc assertion failed");

// next-cycle implication
`define BGC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bgc assertion failed");

`endif

// ----- rtl/core/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgc_pkg
// types and constants shared by the button gesture classifier
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 15;
    localparam int unsigned GEST_W = 3;
    localparam int unsigned CIDX_W = 2;

    localparam logic [TIME_W-1:0] DEBOUNCE_MS = 32'd20;

    localparam logic [CFG_W-1:0] DCW_RESET  = 15'd200;
    localparam logic [CFG_W-1:0] LONG_RESET = 15'd400;
    localparam logic [CFG_W-1:0] VLNG_RESET = 15'd1000;

    localparam logic [GEST_W-1:0] GESTURE_NONE      = 3'd0;
    localparam logic [GEST_W-1:0] GESTURE_CLICK     = 3'd1;
    localparam logic [GEST_W-1:0] GESTURE_DOUBLE    = 3'd2;
    localparam logic [GEST_W-1:0] GESTURE_LONG      = 3'd3;
    localparam logic [GEST_W-1:0] GESTURE_VERY_LONG = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_IDX_DCW  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IDX_LONG = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_IDX_VLNG = 2'd2;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] dcw_ms;
        logic [CFG_W-1:0] long_ms;
        logic [CFG_W-1:0] vlong_ms;
    } bgc_cfg_t;

    typedef struct packed {
        logic              acc_level;
        logic [TIME_W-1:0] last_change;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] prev_press;
        logic              click_pending;
        logic              long_rep;
        logic              vlong_rep;
    } bgc_state_t;

endpackage

// ----- rtl/core/bgc_classify.sv -----
// ----------------------------------------------------------------------------
// bgc_classify
// one-sample debounce and gesture decision, next state and gesture code
// ----------------------------------------------------------------------------
module bgc_classify import bgc_pkg::*; (
    input  bgc_state_t         state_cur,
    input  bgc_cfg_t           cfg,
    input  logic               pin_level,
    input  logic [TIME_W-1:0]  now_ms,
    output bgc_state_t         state_nxt,
    output logic [GEST_W-1:0]  gesture
);

    logic              changed;
    logic              press_evt;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] dcw_ext;
    logic [TIME_W-1:0] long_ext;
    logic [TIME_W-1:0] vlong_ext;
    logic              is_pressed;

    assign dcw_ext   = {{(TIME_W-CFG_W){1'b0}}, cfg.dcw_ms};
    assign long_ext  = {{(TIME_W-CFG_W){1'b0}}, cfg.long_ms};
    assign vlong_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.vlong_ms};

    assign since_change = now_ms - state_cur.last_change;
    assign since_press  = now_ms - state_cur.press_time;
    assign changed      = (pin_level != state_cur.acc_level) && (since_change > DEBOUNCE_MS);
    assign press_evt    = changed && (pin_level == LEVEL_PRESSED);
    assign is_pressed   = changed ? (pin_level == LEVEL_PRESSED)
                                  : (state_cur.acc_level == LEVEL_PRESSED);
    // a new press restarts the hold time at zero
    assign held         = press_evt ? '0 : since_press;

    always_comb begin
        state_nxt = state_cur;
        gesture   = GESTURE_NONE;
        if (changed) begin
            state_nxt.acc_level   = pin_level;
            state_nxt.last_change = now_ms;
        end
        if (press_evt) begin
            state_nxt.click_pending = 1'b1;
            state_nxt.long_rep      = 1'b0;
            state_nxt.vlong_rep     = 1'b0;
            state_nxt.prev_press    = state_cur.press_time;
            state_nxt.press_time    = now_ms;
            if (since_press < dcw_ext) begin
                gesture                 = GESTURE_DOUBLE;
                state_nxt.click_pending = 1'b0;
            end
        end
        if (is_pressed && (held > long_ext) && !state_nxt.long_rep) begin
            gesture                 = GESTURE_LONG;
            state_nxt.long_rep      = 1'b1;
            state_nxt.click_pending = 1'b0;
        end
        if (is_pressed && (held > vlong_ext) && !state_nxt.vlong_rep) begin
            gesture                 = GESTURE_VERY_LONG;
            state_nxt.vlong_rep     = 1'b1;
            state_nxt.click_pending = 1'b0;
        end
        if (state_nxt.click_pending && (held > dcw_ext) && !is_pressed) begin
            gesture                 = GESTURE_CLICK;
            state_nxt.click_pending = 1'b0;
        end
    end

endmodule

// ----- rtl/core/button_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier
// debounced click, double click, long and very long press detection
// ----------------------------------------------------------------------------
//  channel  | ports                       | moves
//  ---------+-----------------------------+-------------------------------
//  sample   | s_valid s_ready s_pin_level | one level sample per transfer
//           | s_now_ms                    |
//  gesture  | m_valid m_ready m_gesture   | one gesture code per sample
//  config   | cfg_we cfg_index cfg_wdata  | register write, no handshake
//
//  one sample per cycle sustained while the gesture side takes each result
//  latency is set by the input register and the result register
//  the classifier state is updated in the cycle a sample leaves the input
//  register, so consecutive samples see each other's effect
//  a stalled result holds the input register, which keeps accepting while empty
//  reset: synchronous active-low aresetn, control, config and state registers return to defaults at once
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_defines.svh"

module button_gesture_classifier import bgc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_pin_level,
    input  logic [TIME_W-1:0]  s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [GEST_W-1:0]  m_gesture,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic              in_valid_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    logic [GEST_W-1:0] out_gesture_reg;
    bgc_cfg_t          cfg_reg;
    bgc_state_t        state_reg;
    bgc_state_t        state_next;
    logic [GEST_W-1:0] gesture_next;
    logic              out_free;
    logic              consume;

    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || consume;
    assign m_valid  = out_valid_reg;
    assign m_gesture = out_gesture_reg;

    bgc_classify u_classify (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .pin_level (in_level_reg),
        .now_ms    (in_now_reg),
        .state_nxt (state_next),
        .gesture   (gesture_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.dcw_ms   <= DCW_RESET;
            cfg_reg.long_ms  <= LONG_RESET;
            cfg_reg.vlong_ms <= VLNG_RESET;
            state_reg.acc_level     <= LEVEL_RELEASED;
            state_reg.last_change   <= '0;
            state_reg.press_time    <= '0;
            state_reg.prev_press    <= '0;
            state_reg.click_pending <= 1'b0;
            state_reg.long_rep      <= 1'b0;
            state_reg.vlong_rep     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IDX_DCW:  cfg_reg.dcw_ms   <= cfg_wdata;
                    CFG_IDX_LONG: cfg_reg.long_ms  <= cfg_wdata;
                    CFG_IDX_VLNG: cfg_reg.vlong_ms <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_pin_level;
            in_now_reg   <= s_now_ms;
        end
        if (consume) begin
            out_gesture_reg <= gesture_next;
        end
    end

    // a pending click never coexists with a reported hold
    `BGC_ASSERT_IMP(a_pending_no_report, state_reg.click_pending,
        !state_reg.long_rep && !state_reg.vlong_rep)
    // a sample waiting on a stalled result stays in the input register
    `BGC_ASSERT_NXT(a_input_held, in_valid_reg && !consume, in_valid_reg)
    // any reported gesture leaves no click pending
    `BGC_ASSERT_NXT(a_gesture_clears_pending, consume && (gesture_next != GESTURE_NONE),
        !state_reg.click_pending)
    // the result register is only reloaded when free
    `BGC_ASSERT_IMP(a_no_overwrite, consume, !out_valid_reg || m_ready)

endmodule

// ----- sim/button_gesture_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// self-checking bench: a directed table of samples, then random press, hold
// and release sequences with bounces and time jumps under several threshold
// settings, each gesture checked against its typed value or an in-bench classifier
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb;
    import bgc_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned PHASES = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 60;

    typedef struct packed {
        logic              lvl;
        logic [TIME_W-1:0] t;
        logic              typed;
        logic [GEST_W-1:0] gest;
    } probe_row_t;

    // typed gestures start from the reset thresholds 200 / 400 / 1000
    localparam probe_row_t PROBES [0:24] = '{
        '{1'b1, 32'd0,          1'b1, GESTURE_NONE},      // idle at reset
        '{1'b0, 32'd20,         1'b0, GESTURE_NONE},      // exactly on debounce
        '{1'b0, 32'd21,         1'b1, GESTURE_DOUBLE},    // near the zero press at reset
        '{1'b0, 32'd421,        1'b0, GESTURE_NONE},      // hold equals long
        '{1'b0, 32'd422,        1'b1, GESTURE_LONG},
        '{1'b0, 32'd1021,       1'b0, GESTURE_NONE},
        '{1'b0, 32'd1022,       1'b1, GESTURE_VERY_LONG},
        '{1'b1, 32'd1030,       1'b0, GESTURE_NONE},
        '{1'b0, 32'd1040,       1'b0, GESTURE_NONE},      // bounce ignored
        '{1'b0, 32'd1300,       1'b0, GESTURE_NONE},
        '{1'b1, 32'd1350,       1'b0, GESTURE_NONE},
        '{1'b1, 32'd1500,       1'b0, GESTURE_NONE},      // equals window
        '{1'b1, 32'd1501,       1'b1, GESTURE_CLICK},
        '{1'b0, 32'd1600,       1'b0, GESTURE_NONE},
        '{1'b1, 32'd1650,       1'b0, GESTURE_NONE},
        '{1'b0, 32'd1700,       1'b1, GESTURE_DOUBLE},
        '{1'b1, 32'd1750,       1'b0, GESTURE_NONE},
        '{1'b1, 32'hFFFF_FFF0,  1'b0, GESTURE_NONE},
        '{1'b0, 32'hFFFF_FFFF,  1'b0, GESTURE_NONE},      // press just before wrap
        '{1'b1, 32'h0000_0020,  1'b0, GESTURE_NONE},
        '{1'b1, 32'h0000_00C9,  1'b1, GESTURE_CLICK},     // click across the wrap
        '{1'b0, 32'h0000_00E0,  1'b0, GESTURE_NONE},
        '{1'b0, 32'h0000_08B0,  1'b1, GESTURE_VERY_LONG}, // long and very long together
        '{1'b0, 32'h0000_08B1,  1'b0, GESTURE_NONE},
        '{1'b1, 32'h0000_0900,  1'b0, GESTURE_NONE}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_pin_level = LEVEL_RELEASED;
    logic [TIME_W-1:0] s_now_ms = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [GEST_W-1:0] m_gesture;
    logic              cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = CFG_IDX_DCW;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // typed expectation that travels with the offered sample
    logic              offer_typed_en = 1'b0;
    logic [GEST_W-1:0] offer_typed = GESTURE_NONE;

    bgc_cfg_t          gest_cfg;
    bgc_state_t        btn_st;
    logic [GEST_W-1:0] expected_gestures [$];
    int unsigned       mismatches = 0;
    int unsigned       stall_cycles = 0;

    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    logic              rx_hold_req = 1'b0;
    logic              rx_hold_done = 1'b0;
    int unsigned       rx_hold_left = 0;

    logic              tx_level = LEVEL_RELEASED;
    logic [TIME_W-1:0] tx_time = '0;

    button_gesture_classifier dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pin_level (s_pin_level),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_gesture   (m_gesture),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // updates the button state for one sample and returns its gesture
    function automatic logic [GEST_W-1:0] classify_sample(input logic lvl,
                                                          input logic [TIME_W-1:0] t);
        logic [GEST_W-1:0] g;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] held;
        g = GESTURE_NONE;
        gap = t - btn_st.last_change;
        if (lvl != btn_st.acc_level && gap > DEBOUNCE_MS) begin
            btn_st.acc_level = lvl;
            btn_st.last_change = t;
            if (lvl == LEVEL_PRESSED) begin
                btn_st.click_pending = 1'b1;
                btn_st.long_rep = 1'b0;
                btn_st.vlong_rep = 1'b0;
                btn_st.prev_press = btn_st.press_time;
                btn_st.press_time = t;
                gap = t - btn_st.prev_press;
                if (gap < TIME_W'(gest_cfg.dcw_ms)) begin
                    g = GESTURE_DOUBLE;
                    btn_st.click_pending = 1'b0;
                end
            end
        end
        held = t - btn_st.press_time;
        if (btn_st.acc_level == LEVEL_PRESSED && held > TIME_W'(gest_cfg.long_ms)
                && !btn_st.long_rep) begin
            g = GESTURE_LONG;
            btn_st.long_rep = 1'b1;
            btn_st.click_pending = 1'b0;
        end
        if (btn_st.acc_level == LEVEL_PRESSED && held > TIME_W'(gest_cfg.vlong_ms)
                && !btn_st.vlong_rep) begin
            g = GESTURE_VERY_LONG;
            btn_st.vlong_rep = 1'b1;
            btn_st.click_pending = 1'b0;
        end
        if (btn_st.click_pending && held > TIME_W'(gest_cfg.dcw_ms)
                && btn_st.acc_level == LEVEL_RELEASED) begin
            g = GESTURE_CLICK;
            btn_st.click_pending = 1'b0;
        end
        return g;
    endfunction

    // register writes, sample transfers and gesture checks, in edge order
    always @(posedge aclk) begin
        logic [GEST_W-1:0] predicted;
        logic [GEST_W-1:0] want;
        if (!aresetn) begin
            gest_cfg.dcw_ms = DCW_RESET;
            gest_cfg.long_ms = LONG_RESET;
            gest_cfg.vlong_ms = VLNG_RESET;
            btn_st = '0;
            btn_st.acc_level = LEVEL_RELEASED;
            expected_gestures.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IDX_DCW:  gest_cfg.dcw_ms = cfg_wdata;
                    CFG_IDX_LONG: gest_cfg.long_ms = cfg_wdata;
                    CFG_IDX_VLNG: gest_cfg.vlong_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = classify_sample(s_pin_level, s_now_ms);
                expected_gestures.push_back(offer_typed_en ? offer_typed : predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_gestures.size() == 0) begin
                    $error("gesture: expected none, actual %0d", m_gesture);
                    mismatches++;
                end else begin
                    want = expected_gestures.pop_front();
                    if (m_gesture !== want) begin
                        $error("gesture: expected %0d, actual %0d", want, m_gesture);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("button_gesture_classifier: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_left = HOLD_OFF_CYCLES;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] t,
                               input logic typed_en, input logic [GEST_W-1:0] typed_gest);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pin_level <= lvl;
        s_now_ms <= t;
        offer_typed_en <= typed_en;
        offer_typed <= typed_gest;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_gestures.size() != 0) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] dcw, input logic [CFG_W-1:0] lng,
                                input logic [CFG_W-1:0] vl, input logic poke_unused);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_DCW;
        cfg_wdata <= dcw;
        @(negedge aclk);
        cfg_index <= CFG_IDX_LONG;
        cfg_wdata <= lng;
        @(negedge aclk);
        cfg_index <= CFG_IDX_VLNG;
        cfg_wdata <= vl;
        @(negedge aclk);
        if (poke_unused) begin
            // no register behind this index, thresholds must stay put
            cfg_index <= CFG_IDX_UNUSED;
            cfg_wdata <= CFG_W'($urandom);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly plausible button activity: bounces, debounce edges and holds
    // that land around a threshold; a few samples jump anywhere in time
    task automatic pick_sample(output logic lvl, output logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] thr;
        if ($urandom_range(0, 99) < 8) begin
            lvl = 1'($urandom);
            t = $urandom;
        end else begin
            lvl = ($urandom_range(0, 99) < 30) ? ~tx_level : tx_level;
            case ($urandom_range(0, 3))
                0: t = tx_time + $urandom_range(1, 19);
                1: t = tx_time + $urandom_range(19, 23);
                2: begin
                    case ($urandom_range(0, 2))
                        0:       thr = TIME_W'(gest_cfg.dcw_ms);
                        1:       thr = TIME_W'(gest_cfg.long_ms);
                        default: thr = TIME_W'(gest_cfg.vlong_ms);
                    endcase
                    t = btn_st.press_time + thr + $urandom_range(0, 4) - 2;
                end
                default: t = tx_time + $urandom_range(1, 600);
            endcase
        end
        tx_level = lvl;
        tx_time = t;
    endtask

    initial begin
        logic              lvl;
        logic [TIME_W-1:0] t;
        logic [CFG_W-1:0]  lng;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 35;
        rx_idle_pct = 56;
        @(negedge aclk);

        foreach (PROBES[i]) begin
            send_sample(PROBES[i].lvl, PROBES[i].t, PROBES[i].typed, PROBES[i].gest);
        end
        tx_level = PROBES[24].lvl;
        tx_time = PROBES[24].t;

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: ;
                1: program_regs('0, '0, '0, 1'b0);
                2: begin
                    program_regs('1, '1, '1, 1'b0);
                    tx_idle_pct = 56;
                    rx_idle_pct = 35;
                end
                3: begin
                    lng = CFG_W'($urandom_range(50, 800));
                    program_regs(CFG_W'($urandom_range(20, 400)), lng,
                                 lng + CFG_W'($urandom_range(0, 1200)), 1'b1);
                end
                4: begin
                    program_regs(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 60)),
                                 CFG_W'($urandom_range(0, 60)), 1'b0);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                default: program_regs('1, '0, CFG_W'($urandom_range(0, 32767)), 1'b1);
            endcase
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 3 && n == 30) begin
                    // let every gesture come back before going on
                    wait_drained();
                end
                if (ph == 4 && n == 10) begin
                    rx_hold_req = 1'b1;
                end
                pick_sample(lvl, t);
                send_sample(lvl, t, 1'b0, GESTURE_NONE);
            end
        end

        wait_drained();
        repeat (4) @(negedge aclk);
        if (mismatches == 0 && expected_gestures.size() == 0) begin
            $display("button_gesture_classifier: match");
        end else begin
            $display("button_gesture_classifier: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bgc_pkg.sv
rtl/core/bgc_classify.sv
rtl/core/button_gesture_classifier.sv
sim/button_gesture_classifier_tb.sv
